@@ rtl/segment_segment_intersection_assert.svh @@
// Assertion macros for the segment pair intersection block.
// Included by the RTL modules that carry concurrent assertions.
`ifndef SEGMENT_SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_SEGMENT_INTERSECTION_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define SSI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define SSI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SSI_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SSI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/ssi_pkg.sv @@
// Shared types and constants of the segment pair intersection block.
// No dependencies; used by the top level and the divider.
package ssi_pkg;
   localparam int COORD_BITS_DEF = 32;
   localparam int T_FRAC         = 32;
   localparam int MARGIN_BITS    = 17;
   localparam int MARGIN_FRAC    = 16;
   localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 17'd3277;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_HIT     = 2'd1,
      KIND_OVERLAP = 2'd2
   } kind_type;
endpackage

@@ rtl/ssi_div.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
// Carries an opaque tag alongside; stages advance together on adv.
module ssi_div #(
   parameter int RW = 68,
   parameter int QW = ssi_pkg::T_FRAC + 1,
   parameter int TW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  logic [RW-1:0] in_num,
   input  logic [RW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [QW-1:0] out_quot,
   output logic [TW-1:0] out_tag
);
   logic          v_ff   [QW];
   logic [RW-1:0] rem_ff [QW];
   logic [RW-1:0] den_ff [QW];
   logic [QW-1:0] q_ff   [QW];
   logic [TW-1:0] tag_ff [QW];

   genvar k;
   for (k = 0; k < QW; k++) begin : g_step
      logic          pv;
      logic [RW-1:0] prem, pden;
      logic [QW-1:0] pq;
      logic [TW-1:0] ptag;
      logic [RW-1:0] src;
      logic [RW:0]   diff;

      // take the previous stage, or the divider input at the first step
      if (k == 0) begin : g_first
         assign pv   = in_valid;
         assign prem = in_num;
         assign src  = prem;
         assign pden = in_den;
         assign pq   = '0;
         assign ptag = in_tag;
      end else begin : g_next
         assign pv   = v_ff[k-1];
         assign prem = rem_ff[k-1];
         assign src  = {prem[RW-2:0], 1'b0};
         assign pden = den_ff[k-1];
         assign pq   = q_ff[k-1];
         assign ptag = tag_ff[k-1];
      end

      // trial subtract, keep the remainder when it goes negative
      assign diff = {1'b0, src} - {1'b0, pden};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= diff[RW] ? src : diff[RW-1:0];
            q_ff[k]   <= {pq[QW-2:0], ~diff[RW]};
            den_ff[k] <= pden;
            tag_ff[k] <= ptag;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_quot  = q_ff[QW-1];
   assign out_tag   = tag_ff[QW-1];
endmodule

@@ rtl/segment_segment_intersection.sv @@
// Top level of the 2D segment pair intersection classifier.
// Depends on ssi_pkg, ssi_div and segment_segment_intersection_assert.svh.
//
// Usage: each request carries segment A (a_start -> a_end) and segment B
// (b_start -> b_end) as signed fixed-point coordinates. The response gives
// cross_kind (none, intersection, collinear overlap), point_valid and the
// saturated hit point. Both channels use valid/stall; a request moves on an
// edge with valid high and stall low. csr_we writes t_lower_margin (Q16).
// Throughput: one request per cycle while req_stall is low. A request passes
// 42 registers, the first loaded at the accepting edge: six for cross
// products and tests, 33 divider stages (one quotient bit each for the
// 32-fraction-bit t), two for the point multiply and saturate, and the
// output register.
// Reset clears all valid bits and loads the margin with 3277 (about 0.05).
// When the receiver stalls, the output holds and one more result parks in
// a skid register; req_stall then rises and the whole pipeline freezes
// until the output is taken. Nothing is lost or repeated.
module segment_segment_intersection #(
   parameter int COORD_BITS = ssi_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ssi_pkg::MARGIN_BITS-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [COORD_BITS-1:0]   req_a_start_x,
   input  logic signed [COORD_BITS-1:0]   req_a_start_y,
   input  logic signed [COORD_BITS-1:0]   req_a_end_x,
   input  logic signed [COORD_BITS-1:0]   req_a_end_y,
   input  logic signed [COORD_BITS-1:0]   req_b_start_x,
   input  logic signed [COORD_BITS-1:0]   req_b_start_y,
   input  logic signed [COORD_BITS-1:0]   req_b_end_x,
   input  logic signed [COORD_BITS-1:0]   req_b_end_y,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_cross_kind,
   output logic                           rsp_point_valid,
   output logic signed [COORD_BITS-1:0]   rsp_hit_x,
   output logic signed [COORD_BITS-1:0]   rsp_hit_y
);
   import ssi_pkg::*;
`include "segment_segment_intersection_assert.svh"

   localparam int CW  = COORD_BITS;
   localparam int DW  = CW + 1;
   localparam int PW  = 2 * DW;
   localparam int XW  = PW + 1;
   localparam int MW  = MARGIN_BITS + XW;
   localparam int LW  = MW + 1;
   localparam int ML  = (XW + 1) / 2;
   localparam int MH  = XW - ML;
   localparam int MLW = MARGIN_BITS + ML;
   localparam int MHW = MARGIN_BITS + MH;
   localparam int RW  = XW + 1;
   localparam int QW  = T_FRAC + 1;
   localparam int PXW = DW + QW + 1;
   localparam int OW  = PXW - T_FRAC;
   localparam int VW  = OW + 1;
   localparam logic signed [PXW-1:0] ROUND_HALF = PXW'(64'sd1 <<< (T_FRAC - 1));
   localparam logic signed [VW-1:0]  SAT_HI = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [VW-1:0]  SAT_LO = {{(VW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   typedef struct packed {
      logic signed [CW-1:0] ax, ay, bx1, by1, bx2, by2;
      logic signed [DW-1:0] rx, ry;
      logic                 ep1, ep2;
   } side_type;

   typedef struct packed {
      kind_type             kind;
      logic                 pv;
      logic                 use_c;
      logic signed [CW-1:0] cx, cy, ax, ay;
      logic signed [DW-1:0] rx, ry;
      logic                 negt;
   } tag_type;

   localparam int TW = $bits(tag_type);

   logic adv;
   logic [MARGIN_BITS-1:0] margin_ff;

   // margin register
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else if (csr_we) begin
         margin_ff <= csr_wdata;
      end
   end

   // stage 1: differences and endpoint matches
   logic                 s1_v_ff;
   side_type             s1_side_ff;
   logic signed [DW-1:0] s1_sx_ff, s1_sy_ff, s1_qx_ff, s1_qy_ff, s1_dx_ff, s1_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_side_ff.ax  <= req_a_start_x;
         s1_side_ff.ay  <= req_a_start_y;
         s1_side_ff.bx1 <= req_b_start_x;
         s1_side_ff.by1 <= req_b_start_y;
         s1_side_ff.bx2 <= req_b_end_x;
         s1_side_ff.by2 <= req_b_end_y;
         s1_side_ff.rx  <= DW'(req_a_end_x) - DW'(req_a_start_x);
         s1_side_ff.ry  <= DW'(req_a_end_y) - DW'(req_a_start_y);
         s1_side_ff.ep1 <= (req_a_start_x == req_b_start_x && req_a_start_y == req_b_start_y)
                        || (req_a_end_x == req_b_start_x && req_a_end_y == req_b_start_y);
         s1_side_ff.ep2 <= (req_a_start_x == req_b_end_x && req_a_start_y == req_b_end_y)
                        || (req_a_end_x == req_b_end_x && req_a_end_y == req_b_end_y);
         s1_sx_ff <= DW'(req_b_end_x) - DW'(req_b_start_x);
         s1_sy_ff <= DW'(req_b_end_y) - DW'(req_b_start_y);
         s1_qx_ff <= DW'(req_b_start_x) - DW'(req_a_start_x);
         s1_qy_ff <= DW'(req_b_start_y) - DW'(req_a_start_y);
         s1_dx_ff <= DW'(req_b_end_x) - DW'(req_a_start_x);
         s1_dy_ff <= DW'(req_b_end_y) - DW'(req_a_start_y);
      end
   end

   // stage 2: products for cross and dot terms
   logic                 s2_v_ff;
   side_type             s2_side_ff;
   logic signed [PW-1:0] s2_rxsy_ff, s2_rysx_ff, s2_qxsy_ff, s2_qysx_ff, s2_qxry_ff;
   logic signed [PW-1:0] s2_qyrx_ff, s2_rxrx_ff, s2_ryry_ff, s2_qxrx_ff, s2_qyry_ff;
   logic signed [PW-1:0] s2_dxrx_ff, s2_dyry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_side_ff <= s1_side_ff;
         s2_rxsy_ff <= s1_side_ff.rx * s1_sy_ff;
         s2_rysx_ff <= s1_side_ff.ry * s1_sx_ff;
         s2_qxsy_ff <= s1_qx_ff * s1_sy_ff;
         s2_qysx_ff <= s1_qy_ff * s1_sx_ff;
         s2_qxry_ff <= s1_qx_ff * s1_side_ff.ry;
         s2_qyrx_ff <= s1_qy_ff * s1_side_ff.rx;
         s2_rxrx_ff <= s1_side_ff.rx * s1_side_ff.rx;
         s2_ryry_ff <= s1_side_ff.ry * s1_side_ff.ry;
         s2_qxrx_ff <= s1_qx_ff * s1_side_ff.rx;
         s2_qyry_ff <= s1_qy_ff * s1_side_ff.ry;
         s2_dxrx_ff <= s1_dx_ff * s1_side_ff.rx;
         s2_dyry_ff <= s1_dy_ff * s1_side_ff.ry;
      end
   end

   // stage 3: cross products and dot products
   logic                 s3_v_ff;
   side_type             s3_side_ff;
   logic signed [XW-1:0] s3_den_ff, s3_nt_ff, s3_nu_ff, s3_rr_ff, s3_d0_ff, s3_d1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_side_ff <= s2_side_ff;
         s3_den_ff  <= XW'(s2_rxsy_ff) - XW'(s2_rysx_ff);
         s3_nt_ff   <= XW'(s2_qxsy_ff) - XW'(s2_qysx_ff);
         s3_nu_ff   <= XW'(s2_qxry_ff) - XW'(s2_qyrx_ff);
         s3_rr_ff   <= XW'(s2_rxrx_ff) + XW'(s2_ryry_ff);
         s3_d0_ff   <= XW'(s2_qxrx_ff) + XW'(s2_qyry_ff);
         s3_d1_ff   <= XW'(s2_dxrx_ff) + XW'(s2_dyry_ff);
      end
   end

   // stage 4: fold the sign of den, order the projection interval
   logic                 s4_v_ff, s4_par_ff, s4_col_ff, s4_rrpos_ff;
   side_type             s4_side_ff;
   logic signed [XW-1:0] s4_aden_ff, s4_snt_ff, s4_snu_ff, s4_lo_ff, s4_hi_ff, s4_rr_ff;
   logic                 s3_neg;
   logic                 s3_swap;

   assign s3_neg  = s3_den_ff[XW-1];
   assign s3_swap = s3_d0_ff > s3_d1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_side_ff  <= s3_side_ff;
         s4_par_ff   <= s3_den_ff == '0;
         s4_col_ff   <= s3_nu_ff == '0;
         s4_rrpos_ff <= s3_rr_ff > 0;
         s4_rr_ff    <= s3_rr_ff;
         s4_aden_ff  <= s3_neg ? -s3_den_ff : s3_den_ff;
         s4_snt_ff   <= s3_neg ? -s3_nt_ff : s3_nt_ff;
         s4_snu_ff   <= s3_neg ? -s3_nu_ff : s3_nu_ff;
         s4_lo_ff    <= s3_swap ? s3_d1_ff : s3_d0_ff;
         s4_hi_ff    <= s3_swap ? s3_d0_ff : s3_d1_ff;
      end
   end

   // stage 5: margin partial products, range tests, collinear verdict
   logic                 s5_v_ff, s5_par_ff, s5_cand_ff;
   side_type             s5_side_ff;
   logic [MLW-1:0]       s5_mlo_ff;
   logic [MHW-1:0]       s5_mhi_ff;
   logic signed [XW-1:0] s5_snt_ff, s5_aden_ff;
   kind_type             s5_ckind_ff;
   logic                 s5_cuse_ff;
   logic signed [CW-1:0] s5_cx_ff, s5_cy_ff;
   kind_type             ckind_in;
   logic                 cuse_in;
   logic                 ov_in;

   assign ov_in = s4_rrpos_ff && (s4_lo_ff <= s4_rr_ff) && !s4_hi_ff[XW-1];

   // collinear cases: B's first endpoint, then its second, then overlap
   always_comb begin
      ckind_in = KIND_NONE;
      cuse_in  = 1'b0;
      if (s4_col_ff) begin
         if (s4_side_ff.ep1 || s4_side_ff.ep2) begin
            ckind_in = KIND_HIT;
            cuse_in  = 1'b1;
         end else if (ov_in) begin
            ckind_in = KIND_OVERLAP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_side_ff  <= s4_side_ff;
         s5_par_ff   <= s4_par_ff;
         s5_mlo_ff   <= MLW'(margin_ff) * MLW'(s4_aden_ff[ML-1:0]);
         s5_mhi_ff   <= MHW'(margin_ff) * MHW'(s4_aden_ff[XW-1:ML]);
         s5_cand_ff  <= !s4_par_ff && (s4_snt_ff <= s4_aden_ff)
                     && !s4_snu_ff[XW-1] && (s4_snu_ff <= s4_aden_ff);
         s5_snt_ff   <= s4_snt_ff;
         s5_aden_ff  <= s4_aden_ff;
         s5_ckind_ff <= ckind_in;
         s5_cuse_ff  <= cuse_in;
         s5_cx_ff    <= s4_side_ff.ep1 ? s4_side_ff.bx1 : s4_side_ff.bx2;
         s5_cy_ff    <= s4_side_ff.ep1 ? s4_side_ff.by1 : s4_side_ff.by2;
      end
   end

   // stage 6: lower bound on t, final kind, divider operands
   logic          s6_v_ff;
   tag_type       s6_tag_ff;
   logic [RW-1:0] s6_num_ff, s6_den_ff;
   logic [LW-1:0] lhs_in;
   logic          hit_in;
   logic          negt_in;

   assign lhs_in  = LW'(s5_mlo_ff) + (LW'(s5_mhi_ff) << ML)
                  + LW'(LW'(s5_snt_ff) <<< MARGIN_FRAC);
   assign hit_in  = s5_cand_ff && !lhs_in[LW-1];
   assign negt_in = s5_snt_ff[XW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s6_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_tag_ff.kind  <= s5_par_ff ? s5_ckind_ff : (hit_in ? KIND_HIT : KIND_NONE);
         s6_tag_ff.pv    <= s5_par_ff ? s5_cuse_ff : hit_in;
         s6_tag_ff.use_c <= s5_par_ff;
         s6_tag_ff.cx    <= s5_cx_ff;
         s6_tag_ff.cy    <= s5_cy_ff;
         s6_tag_ff.ax    <= s5_side_ff.ax;
         s6_tag_ff.ay    <= s5_side_ff.ay;
         s6_tag_ff.rx    <= s5_side_ff.rx;
         s6_tag_ff.ry    <= s5_side_ff.ry;
         s6_tag_ff.negt  <= negt_in;
         s6_num_ff <= RW'($unsigned(negt_in ? -s5_snt_ff : s5_snt_ff));
         s6_den_ff <= RW'($unsigned(s5_aden_ff));
      end
   end

   // quotient t with 32 fraction bits
   logic          dv_v;
   logic [QW-1:0] dv_q;
   logic [TW-1:0] dv_tag_bits;
   tag_type       dv_tag;

   ssi_div #(.RW(RW), .QW(QW), .TW(TW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s6_v_ff),
      .in_num    (s6_num_ff),
      .in_den    (s6_den_ff),
      .in_tag    (s6_tag_ff),
      .out_valid (dv_v),
      .out_quot  (dv_q),
      .out_tag   (dv_tag_bits)
   );

   assign dv_tag = tag_type'(dv_tag_bits);

   // point multiply: r*t plus half a coordinate step
   logic                  sm_v_ff;
   tag_type               sm_tag_ff;
   logic signed [PXW-1:0] sm_px_ff, sm_py_ff;
   logic signed [QW:0]    tq;

   assign tq = dv_tag.negt ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_v_ff <= 1'b0;
      end else if (adv) begin
         sm_v_ff <= dv_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sm_tag_ff <= dv_tag;
         sm_px_ff  <= PXW'(dv_tag.rx) * PXW'(tq) + ROUND_HALF;
         sm_py_ff  <= PXW'(dv_tag.ry) * PXW'(tq) + ROUND_HALF;
      end
   end

   // add to A's start, saturate, select the reported point
   logic                 tail_v_ff;
   kind_type             tail_kind_ff;
   logic                 tail_pv_ff;
   logic signed [CW-1:0] tail_hx_ff, tail_hy_ff;
   logic signed [VW-1:0] vx, vy;
   logic signed [CW-1:0] satx, saty;

   assign vx = VW'(sm_tag_ff.ax) + VW'(OW'(sm_px_ff >>> T_FRAC));
   assign vy = VW'(sm_tag_ff.ay) + VW'(OW'(sm_py_ff >>> T_FRAC));
   assign satx = (vx > SAT_HI) ? CW'(SAT_HI) : (vx < SAT_LO) ? CW'(SAT_LO) : CW'(vx);
   assign saty = (vy > SAT_HI) ? CW'(SAT_HI) : (vy < SAT_LO) ? CW'(SAT_LO) : CW'(vy);

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_v_ff <= 1'b0;
      end else if (adv) begin
         tail_v_ff <= sm_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tail_kind_ff <= sm_tag_ff.kind;
         tail_pv_ff   <= sm_tag_ff.pv;
         tail_hx_ff   <= !sm_tag_ff.pv ? '0 : (sm_tag_ff.use_c ? sm_tag_ff.cx : satx);
         tail_hy_ff   <= !sm_tag_ff.pv ? '0 : (sm_tag_ff.use_c ? sm_tag_ff.cy : saty);
      end
   end

   // output register and skid: freeze the pipeline only when the skid is full
   logic                 out_v_ff, skid_v_ff;
   kind_type             out_kind_ff, skid_kind_ff;
   logic                 out_pv_ff, skid_pv_ff;
   logic signed [CW-1:0] out_hx_ff, out_hy_ff, skid_hx_ff, skid_hy_ff;
   logic                 out_free;

   assign adv      = !skid_v_ff;
   assign out_free = !out_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff  <= skid_v_ff || tail_v_ff;
         skid_v_ff <= 1'b0;
      end else if (adv && tail_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_kind_ff <= skid_v_ff ? skid_kind_ff : tail_kind_ff;
         out_pv_ff   <= skid_v_ff ? skid_pv_ff : tail_pv_ff;
         out_hx_ff   <= skid_v_ff ? skid_hx_ff : tail_hx_ff;
         out_hy_ff   <= skid_v_ff ? skid_hy_ff : tail_hy_ff;
      end else if (adv) begin
         skid_kind_ff <= tail_kind_ff;
         skid_pv_ff   <= tail_pv_ff;
         skid_hx_ff   <= tail_hx_ff;
         skid_hy_ff   <= tail_hy_ff;
      end
   end

   assign req_stall       = skid_v_ff;
   assign rsp_valid       = out_v_ff;
   assign rsp_cross_kind  = out_kind_ff;
   assign rsp_point_valid = out_pv_ff;
   assign rsp_hit_x       = out_hx_ff;
   assign rsp_hit_y       = out_hy_ff;

   // checks on the skid and on the result encoding
   `SSI_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_v_ff, out_v_ff)
   `SSI_ASSERT_NEXT(a_skid_fills, clock, reset, !skid_v_ff && tail_v_ff && out_v_ff && rsp_stall, skid_v_ff)
   `SSI_ASSERT_IMPL(a_point_is_hit, clock, reset, out_v_ff && out_pv_ff, out_kind_ff == KIND_HIT)
   `SSI_ASSERT_IMPL(a_no_point_zero, clock, reset, out_v_ff && !out_pv_ff, out_hx_ff == '0 && out_hy_ff == '0)
endmodule
